// ===== rtl/core/gfrma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^8) region multiply-accumulate package
// Shared types, mode codes, register map and the split-nibble multiply.
// ----------------------------------------------------------------------------
package gfrma_pkg;

  // Configuration register map: eight 64-bit registers at byte address 8*i.
  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned AddrW     = 6;
  localparam int unsigned DataW     = 64;

  localparam logic [RegIdxW-1:0] RegALowLower  = 3'd0;
  localparam logic [RegIdxW-1:0] RegALowUpper  = 3'd1;
  localparam logic [RegIdxW-1:0] RegAHighLower = 3'd2;
  localparam logic [RegIdxW-1:0] RegAHighUpper = 3'd3;
  localparam logic [RegIdxW-1:0] RegBLowLower  = 3'd4;
  localparam logic [RegIdxW-1:0] RegBLowUpper  = 3'd5;
  localparam logic [RegIdxW-1:0] RegBHighLower = 3'd6;
  localparam logic [RegIdxW-1:0] RegBHighUpper = 3'd7;

  // Operation codes carried in the mode field.
  localparam logic [2:0] ModeMul    = 3'd0;
  localparam logic [2:0] ModeMac    = 3'd1;
  localparam logic [2:0] ModeDualMac = 3'd2;
  localparam logic [2:0] ModeXor    = 3'd3;
  localparam logic [2:0] ModeFft    = 3'd4;
  localparam logic [2:0] ModeIfft   = 3'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] source;
    logic [7:0] first;
    logic [7:0] second;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] result0;
    logic [7:0] result1;
    logic       last_out;
  } result_t;

  // One 16-entry byte table held as two 64-bit words, entry k at bits 8k.
  function automatic logic [7:0] nib_lookup(input logic [127:0] tab,
                                            input logic [3:0]   idx);
    return tab[{idx, 3'b000} +: 8];
  endfunction

  // Product of v and a coefficient: low-nibble entry XOR high-nibble entry.
  function automatic logic [7:0] gf_mul(input logic [DataW-1:0] low_lower,
                                        input logic [DataW-1:0] low_upper,
                                        input logic [DataW-1:0] high_lower,
                                        input logic [DataW-1:0] high_upper,
                                        input logic [7:0]       v);
    return nib_lookup({low_upper, low_lower}, v[3:0])
         ^ nib_lookup({high_upper, high_lower}, v[7:4]);
  endfunction

endpackage

// ===== rtl/core/gf256_region_multiply_accumulate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2^8) region multiply-accumulate
// Per-byte region kernel using split-nibble coefficient tables.
// ----------------------------------------------------------------------------
// Usage:
// A byte beat is offered on item_i with start_i high; it is taken at any
// rising edge where busy_o is low. busy_o is tied low, so one beat can be
// accepted in every cycle and the block sustains one byte per clock.
// Each accepted beat produces exactly one result beat on result_o, marked by
// a one-cycle done_o strobe: the beat is first captured in the input register
// (item_q), then the finished result, after the table lookups and XORs, in
// the result register (result_q), whose valid flag drives done_o.
// The receiver cannot stall; results are presented once and must be taken.
// The coefficient tables for sets A and B live in eight 64-bit registers on
// the APB-style port (register i at byte address 8*i, zero wait states).
// Reset clears all tables to zero and drops both pipeline valid flags, so no
// stray result beat appears after reset. Tables must only be rewritten while
// no beat is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gf256_region_multiply_accumulate (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel.
  input  logic                                start_i,
  output logic                                busy_o,
  input  gfrma_pkg::item_t                    item_i,
  // Result channel.
  output logic                                done_o,
  output gfrma_pkg::result_t                  result_o,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gfrma_pkg::AddrW-1:0]         paddr,
  input  logic [gfrma_pkg::DataW-1:0]         pwdata,
  output logic [gfrma_pkg::DataW-1:0]         prdata,
  output logic                                pready
);

  logic [gfrma_pkg::DataW-1:0] regs_q [gfrma_pkg::NumRegs];
  logic [gfrma_pkg::RegIdxW-1:0] reg_idx;
  logic                          reg_wr;

  logic               in_valid_q;
  gfrma_pkg::item_t   item_q;
  logic               out_valid_q;
  gfrma_pkg::result_t result_q;
  gfrma_pkg::result_t result_d;

  logic [7:0] mul_a_src;
  logic [7:0] mul_a_sum;
  logic [7:0] mul_b_src;
  logic [7:0] bfly_y;
  logic [7:0] mul_a_in;

  // --------------------------------------------------------------------------
  // Configuration registers. The byte offset inside a register is ignored.
  // --------------------------------------------------------------------------
  assign reg_idx = paddr[gfrma_pkg::AddrW-1:3];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = regs_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gfrma_pkg::NumRegs; i++) begin
        regs_q[i] <= '0;
      end
    end else if (reg_wr) begin
      regs_q[reg_idx] <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // Input register stage.
  // --------------------------------------------------------------------------
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      item_q <= item_i;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath. The inverse butterfly multiplies y' = source ^ first instead of
  // the source byte, so the A multiplier input is selected by mode.
  // --------------------------------------------------------------------------
  assign bfly_y    = item_q.source ^ item_q.first;
  assign mul_a_in  = (item_q.mode == gfrma_pkg::ModeIfft) ? bfly_y : item_q.source;

  assign mul_a_src = gfrma_pkg::gf_mul(regs_q[gfrma_pkg::RegALowLower],
                                       regs_q[gfrma_pkg::RegALowUpper],
                                       regs_q[gfrma_pkg::RegAHighLower],
                                       regs_q[gfrma_pkg::RegAHighUpper],
                                       mul_a_in);
  assign mul_b_src = gfrma_pkg::gf_mul(regs_q[gfrma_pkg::RegBLowLower],
                                       regs_q[gfrma_pkg::RegBLowUpper],
                                       regs_q[gfrma_pkg::RegBHighLower],
                                       regs_q[gfrma_pkg::RegBHighUpper],
                                       item_q.source);
  assign mul_a_sum = item_q.first ^ mul_a_src;

  always_comb begin
    result_d          = '0;
    result_d.last_out = item_q.last_byte;
    case (item_q.mode)
      gfrma_pkg::ModeMul: begin
        result_d.result0 = mul_a_src;
      end
      gfrma_pkg::ModeMac: begin
        result_d.result0 = mul_a_sum;
      end
      gfrma_pkg::ModeDualMac: begin
        result_d.result0 = mul_a_sum;
        result_d.result1 = item_q.second ^ mul_b_src;
      end
      gfrma_pkg::ModeXor: begin
        result_d.result0 = bfly_y;
      end
      gfrma_pkg::ModeFft: begin
        result_d.result0 = mul_a_sum;
        result_d.result1 = item_q.source ^ mul_a_sum;
      end
      gfrma_pkg::ModeIfft: begin
        result_d.result0 = mul_a_sum;
        result_d.result1 = bfly_y;
      end
      default: begin
        // Undefined modes give zero bytes; the region marker still passes.
        result_d.result0 = '0;
        result_d.result1 = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register stage.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = out_valid_q;
  assign result_o = result_q;

endmodule
